// File: design/aes_pkg.sv
// aes_pkg: shared types, constants and byte functions for the aes block cipher core
// no dependencies
package aes_pkg;

    // state columns and round key entries (one per round, up to 14 rounds)
    localparam int          COLUMNS  = 4;
    localparam int unsigned NB_RKEYS = 15;

    typedef struct packed {
        logic        func;
        logic [63:0] block_hi;
        logic [63:0] block_lo;
    } t_in_word;

    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } t_out_word;

    typedef enum logic [2:0] {
        REG_MODE = 3'd0,
        REG_K3   = 3'd1,
        REG_K2   = 3'd2,
        REG_K1   = 3'd3,
        REG_K0   = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_KEXP = 2'd1,
        ST_RUN  = 2'd2
    } t_state;

    // control handed from the sequencer to the column cells
    typedef struct packed {
        logic load;
        logic dec;
        logic run;
        logic last;
    } t_cell_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

// File: design/aes_col_cell.sv
// aes_col_cell: one state column; sub bytes, mix column and add round key, or their inverses,
// for its column; rows are exchanged with the neighbouring cells for shift rows; depends on aes_pkg
module aes_col_cell
    import aes_pkg::*;
(
    input  logic             i_clk,
    input  aes_pkg::t_cell_ctl i_ctl,
    input  logic [31:0]      i_load,
    input  logic [31:0]      i_key,
    input  logic [7:0]       i_row1,
    input  logic [7:0]       i_row2,
    input  logic [7:0]       i_row3,
    output logic [31:0]      o_col
);
    logic [31:0] r_col;
    logic [31:0] n_col;

    always_comb begin
        logic [7:0] b0, b1, b2, b3, m0, m1, m2, m3;
        logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
        {b0, b1, b2, b3} = '0;
        {m0, m1, m2, m3} = '0;
        {x0, x1, x2, x3} = '0;
        {y0, y1, y2, y3} = '0;
        {z0, z1, z2, z3} = '0;
        n_col = r_col;
        if (i_ctl.run) begin
            if (i_ctl.load) begin
                n_col = i_load ^ i_key;
            end else if (!i_ctl.dec) begin
                b0 = SBOX[r_col[31:24]];
                b1 = SBOX[i_row1];
                b2 = SBOX[i_row2];
                b3 = SBOX[i_row3];
                m0 = xtime(b0) ^ xtime(b1) ^ b1 ^ b2 ^ b3;
                m1 = b0 ^ xtime(b1) ^ xtime(b2) ^ b2 ^ b3;
                m2 = b0 ^ b1 ^ xtime(b2) ^ xtime(b3) ^ b3;
                m3 = xtime(b0) ^ b0 ^ b1 ^ b2 ^ xtime(b3);
                if (i_ctl.last) n_col = {b0, b1, b2, b3} ^ i_key;
                else            n_col = {m0, m1, m2, m3} ^ i_key;
            end else begin
                b0 = ISBOX[r_col[31:24]] ^ i_key[31:24];
                b1 = ISBOX[i_row1] ^ i_key[23:16];
                b2 = ISBOX[i_row2] ^ i_key[15:8];
                b3 = ISBOX[i_row3] ^ i_key[7:0];
                // inverse mix: 14,11,13,9 built from doublings
                x0 = xtime(b0); y0 = xtime(x0); z0 = xtime(y0);
                x1 = xtime(b1); y1 = xtime(x1); z1 = xtime(y1);
                x2 = xtime(b2); y2 = xtime(x2); z2 = xtime(y2);
                x3 = xtime(b3); y3 = xtime(x3); z3 = xtime(y3);
                m0 = (z0^y0^x0) ^ (z1^x1^b1) ^ (z2^y2^b2) ^ (z3^b3);
                m1 = (z0^b0) ^ (z1^y1^x1) ^ (z2^x2^b2) ^ (z3^y3^b3);
                m2 = (z0^y0^b0) ^ (z1^b1) ^ (z2^y2^x2) ^ (z3^x3^b3);
                m3 = (z0^x0^b0) ^ (z1^y1^b1) ^ (z2^b2) ^ (z3^y3^x3);
                if (i_ctl.last) n_col = {b0, b1, b2, b3};
                else            n_col = {m0, m1, m2, m3};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    assign o_col = r_col;
endmodule

// File: design/aes_key_mem.sv
// aes_key_mem: round key expansion, one word a cycle, into a memory of one entry per round
// the cipher reads a whole round key (four words) through a register; depends on aes_pkg
module aes_key_mem
    import aes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [1:0]   i_mode,
    input  logic [255:0] i_key,
    input  logic [3:0]   i_rd_round,
    output logic [127:0] o_rd_key,
    output logic         o_busy
);
    // one entry per round, key word 0 of the round in the top bits
    logic [127:0] r_mem [NB_RKEYS];
    logic [5:0]  r_wp;
    logic [2:0]  r_pos;
    logic        r_busy;
    logic [7:0]  r_rcon;
    logic [31:0] r_w [8];
    logic [3:0]  r_nk;
    logic [5:0]  r_total;
    logic [31:0] n_w;
    logic [127:0] r_rd;

    // r_w holds the last nk words as a sliding window
    always_comb begin
        logic [31:0] t;
        t = r_w[r_nk[2:0] - 3'd1];
        if (r_pos == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {r_rcon, 24'h0};
        end else if (r_nk == 4'd8 && r_pos == 3'd4) begin
            t = sub_word(t);
        end
        n_w = r_w[0] ^ t;
    end

    // the oldest window word is written to memory each cycle, until all total words are stored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_wp    <= 6'd0;
            r_pos   <= 3'd0;
            r_rcon  <= 8'h01;
            r_nk    <= 4'd4;
            r_total <= 6'd44;
            for (int i = 0; i < 8; i++) r_w[i] <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_wp   <= 6'd0;
            r_pos  <= 3'd0;
            r_rcon <= 8'h01;
            case (i_mode)
                2'd0:    begin r_nk <= 4'd4; r_total <= 6'd44; end
                2'd1:    begin r_nk <= 4'd6; r_total <= 6'd52; end
                default: begin r_nk <= 4'd8; r_total <= 6'd60; end
            endcase
            for (int i = 0; i < 8; i++) r_w[i] <= i_key[255 - 32*i -: 32];
        end else if (r_busy) begin
            for (int i = 0; i < 7; i++) begin
                if (3'(i) == r_nk[2:0] - 3'd1) r_w[i] <= n_w;
                else                           r_w[i] <= r_w[i+1];
            end
            if (r_nk == 4'd8) r_w[7] <= n_w;
            if (r_pos == 3'(r_nk - 4'd1)) begin
                r_pos  <= 3'd0;
                r_rcon <= xtime(r_rcon);
            end else begin
                r_pos <= r_pos + 3'd1;
            end
            r_wp <= r_wp + 6'd1;
            if (r_wp == r_total - 6'd1) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_wp[5:2]][127 - 32 * int'(r_wp[1:0]) -: 32] <= r_w[0];
        end
        r_rd <= r_mem[i_rd_round];
    end

    assign o_rd_key = r_rd;
    assign o_busy   = r_busy || i_start;
endmodule

// File: design/aes_block_cipher_core.sv
// aes_block_cipher_core: iterative aes, a row of four column cells, one round at a time
// depends on aes_pkg, aes_col_cell and aes_key_mem
//
// usage: pulse i_start with i_in (func, block_hi, block_lo) while o_busy is low.
// the key and key length are written through i_cfg_we / i_cfg_idx / i_cfg_data
// while idle; every write to registers 0..4 restarts round key expansion, which
// keeps o_busy high until it is done. registers: 0 key length, 1..4 key bits
// from most significant.
// an item runs a key fetch phase and an execute phase for the initial key
// addition and for each of 10, 12 or 14 rounds: o_done is registered at the end
// of the last execute phase and is high for one cycle with o_out.
// one item at a time: o_busy is already low in the o_done cycle, so a new word
// can already be taken in the o_done cycle.
// reset (synchronous, active low) clears the key to zero, sets 128-bit mode and
// expands the zero key; o_busy stays high until that is done. the receiver
// cannot stall: the result is shown for exactly one cycle.
module aes_block_cipher_core
    import aes_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  aes_pkg::t_in_word   i_in,
    output logic                o_busy,
    output logic                o_done,
    output aes_pkg::t_out_word  o_out,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_data
);
    logic [1:0]   r_mode;
    logic [255:0] r_key;
    logic         r_kstart;
    t_state       r_state, n_state;
    logic         r_dec;
    logic [3:0]   r_round;
    logic [3:0]   r_nr;
    logic         r_phase;
    logic [127:0] r_blk;
    logic         r_done;
    logic [127:0] key_rd;
    logic         key_busy;
    logic [3:0]   rd_round;
    logic [31:0]  cols [COLUMNS];
    t_cell_ctl    ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 2'd0;
            r_key    <= '0;
            r_kstart <= 1'b0;
        end else begin
            r_kstart <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE: begin r_mode <= i_cfg_data[1:0]; r_kstart <= 1'b1; end
                    REG_K3:   begin r_key[255:192] <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_K2:   begin r_key[191:128] <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_K1:   begin r_key[127:64]  <= i_cfg_data; r_kstart <= 1'b1; end
                    REG_K0:   begin r_key[63:0]    <= i_cfg_data; r_kstart <= 1'b1; end
                    default:  ;
                endcase
            end
        end
    end

    aes_key_mem u_keys (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_kstart),
        .i_mode    (r_mode),
        .i_key     (r_key),
        .i_rd_round(rd_round),
        .o_rd_key  (key_rd),
        .o_busy    (key_busy)
    );

    // phase 0 fetches the round key, phase 1 runs the round in the cells
    assign rd_round = r_round;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_start && !key_busy && !r_kstart) n_state = ST_RUN;
            ST_RUN:  if (r_phase && r_round == (r_dec ? 4'd0 : r_nr)) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= r_state == ST_RUN && n_state == ST_IDLE;
            if (r_state == ST_IDLE && n_state == ST_RUN) begin
                r_phase <= 1'b0;
                r_dec   <= i_in.func;
                r_blk   <= {i_in.block_hi, i_in.block_lo};
                r_nr    <= (r_mode == 2'd0) ? 4'd10 : (r_mode == 2'd1) ? 4'd12 : 4'd14;
                r_round <= i_in.func ?
                    ((r_mode == 2'd0) ? 4'd10 : (r_mode == 2'd1) ? 4'd12 : 4'd14) : 4'd0;
            end else if (r_state == ST_RUN) begin
                r_phase <= !r_phase;
                if (r_phase) r_round <= r_dec ? r_round - 4'd1 : r_round + 4'd1;
            end
        end
    end

    always_comb begin
        ctl.load = r_phase && (r_dec ? r_round == r_nr : r_round == 4'd0);
        ctl.dec  = r_dec;
        ctl.run  = r_state == ST_RUN && r_phase;
        ctl.last = r_dec ? r_round == 4'd0 : r_round == r_nr;
    end

    // hold the cells except in the execute phase
    for (genvar c = 0; c < COLUMNS; c++) begin : g_col
        t_cell_ctl  cctl;
        logic [31:0] hold;
        assign cctl = ctl;
        aes_col_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (cctl),
            .i_load(r_phase ? r_blk[127 - 32*c -: 32] : 32'h0),
            .i_key (r_phase ? key_rd[127 - 32*c -: 32] : 32'h0),
            .i_row1(r_phase ? (r_dec ? cols[(c+COLUMNS-1)%COLUMNS][23:16]
                                     : cols[(c+1)%COLUMNS][23:16]) : cols[c][23:16]),
            .i_row2(r_phase ? cols[(c+2)%COLUMNS][15:8] : cols[c][15:8]),
            .i_row3(r_phase ? (r_dec ? cols[(c+1)%COLUMNS][7:0]
                                     : cols[(c+COLUMNS-1)%COLUMNS][7:0]) : cols[c][7:0]),
            .o_col (hold)
        );
        assign cols[c] = hold;
    end

    assign o_busy = r_state != ST_IDLE || key_busy || r_kstart;
    assign o_done = r_done;
    assign o_out  = {cols[0], cols[1], cols[2], cols[3]};
endmodule

// File: sim/tb_aes_block_cipher_core.sv
// tb_aes_block_cipher_core: randomised self-checking bench for the aes block cipher core
// depends on aes_pkg and aes_block_cipher_core; predicts each block with its own aes cipher
module tb_aes_block_cipher_core;
    import aes_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    t_in_word    i_in = '0;
    logic        o_busy;
    logic        o_done;
    t_out_word   o_out;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_data = '0;

    int unsigned err_count = 0;
    int unsigned cycle_count = 0;
    localparam int unsigned CYCLE_LIMIT = 400000;

    aes_block_cipher_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- cipher predictor ----------------
    logic [7:0]  inv_sbox [256];
    logic [31:0] key_sched [60];
    logic [63:0] key_bank [4];
    logic [1:0]  klen_mode;

    function automatic int n_rounds();
        return (klen_mode == 2'd0) ? 10 : (klen_mode == 2'd1) ? 12 : 14;
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= a;
            a = xtime(a);
        end
        return r;
    endfunction

    task automatic build_schedule();
        int nr, nk, total;
        logic [7:0]  rc;
        logic [31:0] t;
        nr = n_rounds();
        nk = nr - 6;
        total = 4 * (nr + 1);
        rc = 8'h01;
        for (int i = 0; i < 60; i++) key_sched[i] = '0;
        for (int i = 0; i < nk; i++)
            key_sched[i] = i[0] ? key_bank[i >> 1][31:0] : key_bank[i >> 1][63:32];
        for (int i = nk; i < total; i++) begin
            t = key_sched[i - 1];
            if (i % nk == 0) begin
                t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = xtime(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sub_word(t);
            end
            key_sched[i] = key_sched[i - nk] ^ t;
        end
    endtask

    // state byte at row r, column c is s[4*c + r]
    function automatic t_out_word cipher_block(input t_in_word w);
        logic [7:0] s [16];
        logic [7:0] t [16];
        logic [127:0] blk;
        int nr;
        logic [31:0] kw;
        t_out_word res;
        nr = n_rounds();
        blk = {w.block_hi, w.block_lo};
        for (int n = 0; n < 16; n++) s[n] = blk[127 - 8*n -: 8];
        for (int step = 0; step <= nr; step++) begin
            int rnd;
            rnd = w.func ? nr - step : step;
            if (step > 0) begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        if (w.func) t[4*((c + r) % 4) + r] = inv_sbox[s[4*c + r]];
                        else t[4*c + r] = SBOX[s[4*((c + r) % 4) + r]];
                s = t;
                if (!w.func && step < nr) begin
                    for (int c = 0; c < 4; c++)
                        for (int r = 0; r < 4; r++) begin
                            t[4*c + r] = 8'h00;
                            for (int k = 0; k < 4; k++)
                                t[4*c + r] ^= gf_mul(s[4*c + k],
                                    ((k + 4 - r) % 4 == 0) ? 8'd2 :
                                    ((k + 4 - r) % 4 == 1) ? 8'd3 : 8'd1);
                        end
                    s = t;
                end
            end
            for (int c = 0; c < 4; c++) begin
                kw = key_sched[(rnd * 4 + c) % 60];
                for (int r = 0; r < 4; r++) s[4*c + r] ^= kw[31 - 8*r -: 8];
            end
            if (w.func && step > 0 && step < nr) begin
                for (int c = 0; c < 4; c++)
                    for (int r = 0; r < 4; r++) begin
                        t[4*c + r] = 8'h00;
                        for (int k = 0; k < 4; k++)
                            t[4*c + r] ^= gf_mul(s[4*c + k],
                                ((k + 4 - r) % 4 == 0) ? 8'd14 :
                                ((k + 4 - r) % 4 == 1) ? 8'd11 :
                                ((k + 4 - r) % 4 == 2) ? 8'd13 : 8'd9);
                    end
                s = t;
            end
        end
        for (int n = 0; n < 16; n++) blk[127 - 8*n -: 8] = s[n];
        res.result_hi = blk[127:64];
        res.result_lo = blk[63:0];
        return res;
    endfunction

    // ---------------- scoreboard ----------------
    class block_scoreboard;
        t_out_word pending_blocks[$];

        function void note_block(input t_out_word exp_word);
            pending_blocks.push_back(exp_word);
        endfunction

        function void check_block(input t_out_word got);
            t_out_word exp_word;
            if (pending_blocks.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                err_count++;
                return;
            end
            exp_word = pending_blocks.pop_front();
            if (got.result_hi !== exp_word.result_hi) begin
                $display("%0t result_hi expected %h actual %h", $time,
                         exp_word.result_hi, got.result_hi);
                err_count++;
            end
            if (got.result_lo !== exp_word.result_lo) begin
                $display("%0t result_lo expected %h actual %h", $time,
                         exp_word.result_lo, got.result_lo);
                err_count++;
            end
        endfunction
    endclass

    block_scoreboard sb = new();

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_block(o_out);
    end

    // ---------------- driving tasks ----------------
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MODE) klen_mode = val[1:0];
        else key_bank[idx - 1] = val;
        build_schedule();
    endtask

    task automatic write_bad_index(input logic [2:0] idx);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= {$urandom, $urandom};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_block(input t_in_word w);
        int gap;
        gap = $urandom_range(0, 4);
        repeat (gap) @(posedge i_clk);
        // busy is sampled just before the edge
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        i_start <= 1'b1;
        i_in    <= w;
        sb.note_block(cipher_block(w));
        @(posedge i_clk);
        i_start <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending_blocks.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_in_word rand_block();
        t_in_word w;
        w.func     = 1'($urandom_range(0, 1));
        w.block_hi = {$urandom, $urandom};
        w.block_lo = {$urandom, $urandom};
        return w;
    endfunction

    function automatic logic [63:0] rand_key_part();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        t_in_word w;
        for (int i = 0; i < 256; i++) inv_sbox[SBOX[i]] = i[7:0];
        for (int i = 0; i < 4; i++) key_bank[i] = '0;
        klen_mode = 2'd0;
        build_schedule();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero key, edge blocks, both directions
        for (int f = 0; f < 2; f++) begin
            w.func = f[0];
            w.block_hi = '0; w.block_lo = '0;   send_block(w);
            w.block_hi = '1; w.block_lo = '1;   send_block(w);
            w.block_hi = 64'h0011223344556677; w.block_lo = 64'h8899aabbccddeeff;
            send_block(w);
        end
        drain();
        // standard vectors per key length, mode three behaves as 256-bit
        write_reg(REG_K3, 64'h0001020304050607);
        write_reg(REG_K2, 64'h08090a0b0c0d0e0f);
        write_reg(REG_K1, 64'h1011121314151617);
        write_reg(REG_K0, 64'h18191a1b1c1d1e1f);
        for (int m = 0; m < 4; m++) begin
            write_reg(REG_MODE, 64'(m));
            write_bad_index(3'(5 + m % 3));
            for (int f = 0; f < 2; f++) begin
                w.func = f[0];
                w.block_hi = 64'h0011223344556677; w.block_lo = 64'h8899aabbccddeeff;
                send_block(w);
                send_block(rand_block());
            end
            drain();
        end

        // random phases: new key settings, then blocks
        for (int ph = 0; ph < 30; ph++) begin
            write_reg(REG_MODE, 64'($urandom_range(0, 3)));
            write_reg(REG_K3, rand_key_part());
            write_reg(REG_K2, rand_key_part());
            write_reg(REG_K1, rand_key_part());
            write_reg(REG_K0, rand_key_part());
            for (int i = 0; i < 50; i++) begin
                send_block(rand_block());
                if (i == 25) drain();
            end
            drain();
        end

        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

// File: sim.f
design/aes_pkg.sv
design/aes_col_cell.sv
design/aes_key_mem.sv
design/aes_block_cipher_core.sv
sim/tb_aes_block_cipher_core.sv
